// ===== rtl/voxel_record_set_hash_unit_defines.svh =====
// Assertion macros for the voxel record set hash unit.
`ifndef VOXEL_RECORD_SET_HASH_UNIT_DEFINES_SVH
`define VOXEL_RECORD_SET_HASH_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VRSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VRSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vrsh_pkg.sv =====
// Types, constants and mixing functions shared by the voxel record set hash unit.
package vrsh_pkg;

    localparam logic [31:0] MIX_BASIS  = 32'h811c_9dc5;
    localparam logic [31:0] MIX_OFS_X  = 32'h9e37_79b9;
    localparam logic [31:0] MIX_OFS_Y  = 32'h85eb_ca77;
    localparam logic [31:0] MIX_OFS_Z  = 32'hc2b2_ae3d;
    localparam logic [63:0] FOLD_BASIS = 64'hcbf2_9ce4_8422_2325;
    localparam logic [15:0] MAX_VALUE_RESET = 16'hffff;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MIX,
        F_PUSH
    } t_front_state;

    // One classified record on its way from front to back.
    typedef struct packed {
        logic [31:0] word;
        logic        bad;
        logic        last;
    } t_rec;

    // (h ^ v) * 0x01000193 mod 2^32, prime bits 0,1,4,7,8,24.
    function automatic logic [31:0] f_mix(input logic [31:0] h, input logic [31:0] v);
        logic [31:0] p;
        p = h ^ v;
        return p + (p << 1) + (p << 4) + (p << 7) + (p << 8) + (p << 24);
    endfunction

    // (a ^ w) * 0x100000001b3 mod 2^64, prime bits 0,1,4,5,7,8,40.
    function automatic logic [63:0] f_fold(input logic [63:0] a, input logic [31:0] w);
        logic [63:0] q;
        q = a ^ {32'd0, w};
        return q + (q << 1) + (q << 4) + (q << 5) + (q << 7) + (q << 8) + (q << 40);
    endfunction

endpackage

// ===== rtl/vrsh_front.sv =====
// Front end: takes records, checks the cell value, mixes the record into a 32-bit word.
module vrsh_front import vrsh_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [31:0]  i_pos_x,
    input  logic [31:0]  i_pos_y,
    input  logic [31:0]  i_pos_z,
    input  logic [15:0]  i_cell_value,
    input  logic         i_last,
    output logic         o_push_valid,
    input  logic         i_push_ready,
    output t_rec         o_push_data
);

    t_front_state r_state, n_state;
    logic [1:0]   r_step;
    logic [31:0]  r_h;
    logic [31:0]  r_ox, r_oy, r_oz;
    logic [15:0]  r_v;
    logic         r_bad, r_last;
    logic [15:0]  r_max;
    logic [31:0]  mix_in;
    logic         accept;

    always_comb begin
        unique case (r_step)
            2'd0:    mix_in = r_ox;
            2'd1:    mix_in = r_oy;
            2'd2:    mix_in = r_oz;
            default: mix_in = {16'd0, r_v};
        endcase
    end

    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_push_valid = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = F_MIX;
            end
            F_MIX: begin
                if (r_step == 2'd3) n_state = F_PUSH;
            end
            F_PUSH: begin
                o_push_valid = 1'b1;
                o_ready      = i_push_ready;
                if (i_push_ready) n_state = i_valid ? F_MIX : F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign accept      = i_valid && o_ready;
    assign o_push_data = '{word: r_h, bad: r_bad, last: r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_max   <= MAX_VALUE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_max <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ox   <= i_pos_x + MIX_OFS_X;
            r_oy   <= i_pos_y + MIX_OFS_Y;
            r_oz   <= i_pos_z + MIX_OFS_Z;
            r_v    <= i_cell_value;
            r_bad  <= (i_cell_value == 16'd0) || (i_cell_value > r_max);
            r_last <= i_last;
            r_h    <= MIX_BASIS;
            r_step <= 2'd0;
        end else if (r_state == F_MIX) begin
            r_h    <= f_mix(r_h, mix_in);
            r_step <= r_step + 2'd1;
        end
    end

endmodule

// ===== rtl/vrsh_queue.sv =====
// Small FIFO of classified records between front and back.
module vrsh_queue import vrsh_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_rec i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_rec o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= f_next(r_wr_ptr);
            if (pop)  r_rd_ptr <= f_next(r_rd_ptr);
            if (push && !pop)      r_count <= r_count + CNT_W'(1);
            else if (pop && !push) r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_push_data;
    end

endmodule

// ===== rtl/vrsh_back.sv =====
// Back end: folds record words into the 64-bit set hash and holds the result item.
module vrsh_back import vrsh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_rec        i_pop_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_running_hash,
    output logic        o_invalid,
    output logic        o_set_done
);

`include "voxel_record_set_hash_unit_defines.svh"

    logic [63:0] r_acc, n_acc;
    logic        r_bad, n_bad;
    logic        r_out_valid;
    logic [63:0] r_out_hash;
    logic        r_out_invalid, r_out_last;
    logic        pop;

    assign o_pop_ready = !r_out_valid || i_ready;
    assign pop         = i_pop_valid && o_pop_ready;

    always_comb begin
        n_bad = r_bad || i_pop_data.bad;
        n_acc = i_pop_data.bad ? r_acc : f_fold(r_acc, i_pop_data.word);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= FOLD_BASIS;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_out_valid <= 1'b1;
                // set closes: back to the offset basis
                r_acc <= i_pop_data.last ? FOLD_BASIS : n_acc;
                r_bad <= i_pop_data.last ? 1'b0 : n_bad;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_hash    <= n_bad ? 64'd0 : n_acc;
            r_out_invalid <= n_bad;
            r_out_last    <= i_pop_data.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_running_hash = r_out_hash;
    assign o_invalid      = r_out_invalid;
    assign o_set_done     = r_out_last;

    `VRSH_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, r_out_valid && r_out_invalid, r_out_hash == 64'd0, "invalid result carries a nonzero hash")
    `VRSH_ASSERT_NEXT(a_set_restart, i_clk, i_rst_n, pop && i_pop_data.last, (r_acc == FOLD_BASIS) && !r_bad, "state not restarted after set end")
    `VRSH_ASSERT_NEXT(a_bad_keeps_acc, i_clk, i_rst_n, pop && i_pop_data.bad && !i_pop_data.last, $stable(r_acc) && r_bad, "bad record changed the hash")
    `VRSH_ASSERT_NEXT(a_pop_fills_out, i_clk, i_rst_n, pop, r_out_valid, "popped record produced no result")

endmodule

// ===== rtl/voxel_record_set_hash_unit.sv =====
// Each record (x, y, z, cell value) is mixed into a 32-bit word by four rounds of a
// shared 32-bit multiply-by-prime unit in the front end, which takes no new record while
// it mixes one; a small queue decouples it from the back end, which folds one word per
// cycle, unless its output stalls, into the 64-bit FNV-1a accumulator and holds the
// result item in an output register. Every item gives one result: the running hash (0
// once a bad cell value has been seen in the set), an invalid flag, and tlast copied
// from the input. After a result with tlast the hash restarts from the offset basis.
// max_value is written through i_cfg_we/i_cfg_wdata by the user only while the unit is
// idle (unchecked by the block); a value of 0 marks every record invalid.
module voxel_record_set_hash_unit import vrsh_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [111:0] i_s_axis_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64], cell_value[111:96]
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata,   // running_hash[63:0]
    output logic         o_m_axis_tuser,   // invalid[0]
    output logic         o_m_axis_tlast
);

    logic f_push_valid, f_push_ready;
    t_rec f_push_data;
    logic q_pop_valid, q_pop_ready;
    t_rec q_pop_data;

    vrsh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_pos_x      (i_s_axis_tdata[31:0]),
        .i_pos_y      (i_s_axis_tdata[63:32]),
        .i_pos_z      (i_s_axis_tdata[95:64]),
        .i_cell_value (i_s_axis_tdata[111:96]),
        .i_last       (i_s_axis_tlast),
        .o_push_valid (f_push_valid),
        .i_push_ready (f_push_ready),
        .o_push_data  (f_push_data)
    );

    vrsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_push_valid),
        .o_push_ready (f_push_ready),
        .i_push_data  (f_push_data),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop_data   (q_pop_data)
    );

    vrsh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (q_pop_valid),
        .o_pop_ready    (q_pop_ready),
        .i_pop_data     (q_pop_data),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_running_hash (o_m_axis_tdata),
        .o_invalid      (o_m_axis_tuser),
        .o_set_done     (o_m_axis_tlast)
    );

endmodule
